/* rtl/glos_pkg.sv */
// Shared types and constants of the grid line-of-sight checker.
// Used by glos_div and grid_line_of_sight_check; depends on nothing.
package glos_pkg;

  localparam int GRID_CELLS = 65536;
  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int REG_W      = IDX_W + 1;
  localparam int THR_W      = 9;
  localparam int COST_W     = 8;
  localparam int SIDX_W     = IDX_W + 3;
  localparam int DIV_CNT_W  = $clog2(IDX_W);

  typedef logic [IDX_W-1:0]         coord_t;
  typedef logic [REG_W-1:0]         reg_t;
  typedef logic [THR_W-1:0]         thr_t;
  typedef logic [COST_W-1:0]        cost_t;
  typedef logic signed [SIDX_W-1:0] sidx_t;
  typedef logic [1:0]               cfg_idx_t;
  typedef logic [DIV_CNT_W-1:0]     div_cnt_t;

  localparam div_cnt_t DIV_LAST = div_cnt_t'(IDX_W - 1);

  localparam cfg_idx_t REG_GRID_WIDTH   = 2'd0;
  localparam cfg_idx_t REG_CELL_COUNT   = 2'd1;
  localparam cfg_idx_t REG_CHEAP_THRESH = 2'd2;

  localparam reg_t RST_GRID_WIDTH   = 17'd256;
  localparam reg_t RST_CELL_COUNT   = 17'd65536;
  localparam thr_t RST_CHEAP_THRESH = 9'd150;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    coord_t quot;
    coord_t rem;
  } div_res_t;

endpackage

/* rtl/glos_div.sv */
// Bit-serial restoring divider: splits a cell index into row and column.
// One quotient bit per cycle; depends on glos_pkg.
module glos_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  glos_pkg::coord_t    dividend,
  input  glos_pkg::reg_t      divisor,
  output logic                done,
  output glos_pkg::div_res_t  res
);

  logic                       busy_r;
  logic                       done_r;
  logic [glos_pkg::DIV_CNT_W-1:0] cnt_r;
  glos_pkg::coord_t           quo_r;
  glos_pkg::reg_t             rem_r;
  glos_pkg::reg_t             dvs_r;
  glos_pkg::reg_t             trial;
  logic                       fits;

  assign trial = {rem_r[glos_pkg::IDX_W-1:0], quo_r[glos_pkg::IDX_W-1]};
  assign fits  = (trial >= dvs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= glos_pkg::DIV_LAST;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[glos_pkg::IDX_W-2:0], fits};
        rem_r <= fits ? (trial - dvs_r) : trial;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r[glos_pkg::IDX_W-1:0];

endmodule

/* rtl/grid_line_of_sight_check.sv */
// Grid line-of-sight checker: cost grid memory and Theta*-style line walker.
// Timing: a write word never raises busy; a query holds busy while glos_div splits both
// indices and the walker sets up, then for each major-axis step (up to two
// reads of the single grid read port); a blocked cell ends the walk early.
// Throughput: one word at a time; a zero grid width answers the cycle after the start.
// Reset: synchronous, active low; registers return to 256, 65536, 150; no grid reset.
module grid_line_of_sight_check (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_action,
  input  glos_pkg::coord_t        in_start_index,
  input  glos_pkg::coord_t        in_end_index,
  input  glos_pkg::cost_t         in_cell_cost,
  output logic                    out_valid,
  output logic                    out_sight_clear,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  glos_pkg::cfg_idx_t      cfg_index,
  input  glos_pkg::reg_t          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVA, S_DIVB, S_SETUP, S_LOOP, S_ACC, S_MID, S_PAIR, S_ADV, S_RD, S_EV
  } state_t;

  typedef enum logic [1:0] {
    K_CROSS, K_SIDE, K_PAIR1, K_PAIR2
  } kind_t;

  state_t                 state_r;
  kind_t                  kind_r;
  glos_pkg::reg_t         grid_width_r;
  glos_pkg::reg_t         cell_count_r;
  glos_pkg::thr_t         thr_r;
  glos_pkg::coord_t       end_idx_r;
  glos_pkg::coord_t       x0_r, y0_r, x1_r, y1_r;
  glos_pkg::coord_t       dmaj_r, dmin_r, cnt_r;
  glos_pkg::reg_t         acc_r;
  glos_pkg::sidx_t        cur_r, maj_step_r, min_step_r, off_a_r, off_b1_r, off_b2_r;
  glos_pkg::sidx_t        chk_idx_r;
  logic                   inr_r;
  logic                   out_valid_r;
  logic                   out_clear_r;

  glos_pkg::cost_t        grid_mem_r [glos_pkg::GRID_CELLS];
  glos_pkg::cost_t        rd_data_r;

  logic                   accept;
  logic                   wr_en;
  logic                   div_go;
  glos_pkg::coord_t       div_dividend;
  logic                   div_done;
  glos_pkg::div_res_t     div_res;

  logic                   x_neg, y_neg, xmaj;
  glos_pkg::coord_t       adx, ady;
  glos_pkg::sidx_t        ws, ox, oyw, xstep, ystep;
  glos_pkg::reg_t         acc_sum;
  logic                   acc_ge;
  logic                   in_range;
  logic                   cell_ok;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = !busy && !start;
  assign accept    = start && !busy;
  assign wr_en     = accept && (in_action == glos_pkg::ACT_WRITE);

  assign div_go       = (accept && (in_action == glos_pkg::ACT_QUERY) && (grid_width_r != '0))
                        || ((state_r == S_DIVA) && div_done);
  assign div_dividend = (state_r == S_DIVA) ? end_idx_r : in_start_index;

  glos_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (div_go),
    .dividend (div_dividend),
    .divisor  (grid_width_r),
    .done     (div_done),
    .res      (div_res)
  );

  always_comb begin
    x_neg = (x1_r < x0_r);
    y_neg = (y1_r < y0_r);
    adx   = x_neg ? (x0_r - x1_r) : (x1_r - x0_r);
    ady   = y_neg ? (y0_r - y1_r) : (y1_r - y0_r);
    xmaj  = (adx >= ady);
    ws    = glos_pkg::sidx_t'({2'b00, grid_width_r});
    ox    = x_neg ? -glos_pkg::sidx_t'(1) : '0;
    oyw   = y_neg ? -ws : '0;
    xstep = x_neg ? -glos_pkg::sidx_t'(1) : glos_pkg::sidx_t'(1);
    ystep = y_neg ? -ws : ws;
  end

  assign acc_sum  = acc_r + {1'b0, dmin_r};
  assign acc_ge   = (acc_sum >= {1'b0, dmaj_r});
  assign in_range = !chk_idx_r[glos_pkg::SIDX_W-1] && (chk_idx_r != '0)
                    && (chk_idx_r[glos_pkg::SIDX_W-2:glos_pkg::IDX_W] == '0)
                    && ({1'b0, chk_idx_r[glos_pkg::IDX_W-1:0]} < cell_count_r);
  assign cell_ok  = inr_r && ({1'b0, rd_data_r} < thr_r);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem_r[in_start_index] <= in_cell_cost;
    end
    rd_data_r <= grid_mem_r[chk_idx_r[glos_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      kind_r       <= K_CROSS;
      grid_width_r <= glos_pkg::RST_GRID_WIDTH;
      cell_count_r <= glos_pkg::RST_CELL_COUNT;
      thr_r        <= glos_pkg::RST_CHEAP_THRESH;
      out_valid_r  <= 1'b0;
      out_clear_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          glos_pkg::REG_GRID_WIDTH:   grid_width_r <= cfg_data;
          glos_pkg::REG_CELL_COUNT:   cell_count_r <= cfg_data;
          glos_pkg::REG_CHEAP_THRESH: thr_r        <= cfg_data[glos_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (accept && (in_action == glos_pkg::ACT_QUERY)) begin
            end_idx_r <= in_end_index;
            cur_r     <= glos_pkg::sidx_t'({3'b000, in_start_index});
            if (grid_width_r == '0) begin
              out_valid_r <= 1'b1;
              out_clear_r <= 1'b0;
            end else begin
              state_r <= S_DIVA;
            end
          end
        end
        S_DIVA: begin
          if (div_done) begin
            x0_r    <= div_res.rem;
            y0_r    <= div_res.quot;
            state_r <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (div_done) begin
            x1_r    <= div_res.rem;
            y1_r    <= div_res.quot;
            state_r <= S_SETUP;
          end
        end
        S_SETUP: begin
          dmaj_r     <= xmaj ? adx : ady;
          dmin_r     <= xmaj ? ady : adx;
          cnt_r      <= xmaj ? adx : ady;
          acc_r      <= '0;
          maj_step_r <= xmaj ? xstep : ystep;
          min_step_r <= xmaj ? ystep : xstep;
          off_a_r    <= ox + oyw;
          off_b1_r   <= xmaj ? ox : oyw;
          off_b2_r   <= xmaj ? (ox - ws) : (oyw - glos_pkg::sidx_t'(1));
          state_r    <= S_LOOP;
        end
        S_LOOP: begin
          if (cnt_r == '0) begin
            out_valid_r <= 1'b1;
            out_clear_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_ge) begin
            acc_r     <= acc_sum - {1'b0, dmaj_r};
            chk_idx_r <= cur_r + off_a_r;
            kind_r    <= K_CROSS;
            state_r   <= S_RD;
          end else begin
            acc_r   <= acc_sum;
            state_r <= S_MID;
          end
        end
        S_MID: begin
          if (acc_r != '0) begin
            chk_idx_r <= cur_r + off_a_r;
            kind_r    <= K_SIDE;
            state_r   <= S_RD;
          end else begin
            state_r <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (dmin_r == '0) begin
            chk_idx_r <= cur_r + off_b1_r;
            kind_r    <= K_PAIR1;
            state_r   <= S_RD;
          end else begin
            state_r <= S_ADV;
          end
        end
        S_ADV: begin
          cur_r   <= cur_r + maj_step_r;
          cnt_r   <= cnt_r - 1'b1;
          state_r <= S_LOOP;
        end
        S_RD: begin
          inr_r   <= in_range;
          state_r <= S_EV;
        end
        S_EV: begin
          if (kind_r == K_PAIR1 && !cell_ok) begin
            chk_idx_r <= cur_r + off_b2_r;
            kind_r    <= K_PAIR2;
            state_r   <= S_RD;
          end else if (!cell_ok) begin
            out_valid_r <= 1'b1;
            out_clear_r <= 1'b0;
            state_r     <= S_IDLE;
          end else begin
            case (kind_r)
              K_CROSS: begin
                cur_r   <= cur_r + min_step_r;
                state_r <= S_MID;
              end
              K_SIDE:  state_r <= S_PAIR;
              default: state_r <= S_ADV;
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sight_clear = out_clear_r;

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_query_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_action == glos_pkg::ACT_QUERY) |=> (busy || out_valid))
    else $error("query dropped");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIVA || state_r == S_DIVB))
    else $error("divider finished outside a split state");

  a_eval_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EV) |-> $past(state_r == S_RD))
    else $error("cell evaluated without a read");

endmodule

/* test/testbench.sv */
// Self-checking testbench for grid_line_of_sight_check: a directed plan, then random
// cell writes and line queries, each query checked against a behavioral predictor or a directed expected value.
// Depends on glos_pkg and the grid_line_of_sight_check RTL.
module testbench;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int PHASE_WORDS = 128;

  typedef struct {
    bit                 is_reg;
    glos_pkg::cfg_idx_t reg_sel;
    glos_pkg::reg_t     reg_val;
    logic               act;
    glos_pkg::coord_t   from_cell;
    glos_pkg::coord_t   to_cell;
    glos_pkg::cost_t    cost;
    bit                 known;
    bit                 want;
  } plan_row_t;

  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               start           = 1'b0;
  logic               busy;
  logic               in_action       = glos_pkg::ACT_WRITE;
  glos_pkg::coord_t   in_start_index  = '0;
  glos_pkg::coord_t   in_end_index    = '0;
  glos_pkg::cost_t    in_cell_cost    = '0;
  logic               out_valid;
  logic               out_sight_clear;
  logic               cfg_valid       = 1'b0;
  logic               cfg_ready;
  glos_pkg::cfg_idx_t cfg_index       = glos_pkg::REG_GRID_WIDTH;
  glos_pkg::reg_t     cfg_data        = '0;

  glos_pkg::reg_t  grid_w_q    = glos_pkg::RST_GRID_WIDTH;
  glos_pkg::reg_t  cell_cnt_q  = glos_pkg::RST_CELL_COUNT;
  glos_pkg::thr_t  cheap_thr_q = glos_pkg::RST_CHEAP_THRESH;
  glos_pkg::cost_t grid_cost [glos_pkg::GRID_CELLS];
  bit              cell_written [glos_pkg::GRID_CELLS];
  int              unwritten_at;

  bit        clear_bits_due [$];
  plan_row_t plan [$];
  int        items_sent  = 0;
  int        idle_pct    = 0;
  int        error_count = 0;
  int        cycle_count = 0;

  grid_line_of_sight_check DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_action       (in_action),
    .in_start_index  (in_start_index),
    .in_end_index    (in_end_index),
    .in_cell_cost    (in_cell_cost),
    .out_valid       (out_valid),
    .out_sight_clear (out_sight_clear),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic flag_error(string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  function automatic bit cell_passable(longint col, longint row);
    longint idx;
    idx = col + row * longint'(grid_w_q);
    if (idx <= 0 || idx >= longint'(cell_cnt_q) || idx >= glos_pkg::GRID_CELLS) return 1'b0;
    if (!cell_written[idx]) begin
      if (unwritten_at < 0) unwritten_at = int'(idx);
      return 1'b0;
    end
    return grid_cost[idx] < cheap_thr_q;
  endfunction

  // Walk the whole line and AND every check; this also records the first unwritten cell touched.
  function automatic bit line_is_clear(glos_pkg::coord_t a, glos_pkg::coord_t b);
    longint w, x0, y0, x1, y1, dx, dy, stx, sty, ox, oy, acc;
    bit ok, near_a, near_b;
    if (grid_w_q == '0) return 1'b0;
    w = longint'(grid_w_q);
    x0 = longint'(a) % w;
    y0 = longint'(a) / w;
    x1 = longint'(b) % w;
    y1 = longint'(b) / w;
    dx = x1 - x0;
    dy = y1 - y0;
    stx = 1;
    sty = 1;
    acc = 0;
    ok = 1'b1;
    if (dy < 0) begin
      dy = -dy;
      sty = -1;
    end
    if (dx < 0) begin
      dx = -dx;
      stx = -1;
    end
    ox = (stx < 0) ? -1 : 0;
    oy = (sty < 0) ? -1 : 0;
    if (dx >= dy) begin
      while (x0 != x1) begin
        acc += dy;
        if (acc >= dx) begin
          ok &= cell_passable(x0 + ox, y0 + oy);
          y0 += sty;
          acc -= dx;
        end
        if (acc != 0) ok &= cell_passable(x0 + ox, y0 + oy);
        if (dy == 0) begin
          near_a = cell_passable(x0 + ox, y0);
          near_b = cell_passable(x0 + ox, y0 - 1);
          ok &= near_a | near_b;
        end
        x0 += stx;
      end
    end else begin
      while (y0 != y1) begin
        acc += dx;
        if (acc >= dy) begin
          ok &= cell_passable(x0 + ox, y0 + oy);
          x0 += stx;
          acc -= dy;
        end
        if (acc != 0) ok &= cell_passable(x0 + ox, y0 + oy);
        if (dx == 0) begin
          near_a = cell_passable(x0, y0 + oy);
          near_b = cell_passable(x0 - 1, y0 + oy);
          ok &= near_a | near_b;
        end
        y0 += sty;
      end
    end
    return ok;
  endfunction

  function automatic glos_pkg::cost_t pick_cost();
    int top;
    top = (cheap_thr_q > 9'd256) ? 256 : int'(cheap_thr_q);
    if (top == 0 || $urandom_range(0, 15) == 0) return glos_pkg::cost_t'($urandom);
    return glos_pkg::cost_t'($urandom_range(0, top - 1));
  endfunction

  function automatic glos_pkg::coord_t pick_cell();
    longint span;
    span = longint'(grid_w_q) * 16;
    if (span < 64) span = 64;
    if (span > glos_pkg::GRID_CELLS) span = glos_pkg::GRID_CELLS;
    if ($urandom_range(0, 15) == 0) return glos_pkg::coord_t'($urandom);
    return glos_pkg::coord_t'($urandom_range(0, int'(span - 1)));
  endfunction

  function automatic void add_word(logic act, glos_pkg::coord_t from_cell,
                                   glos_pkg::coord_t to_cell, glos_pkg::cost_t cost,
                                   bit known, bit want);
    plan_row_t row;
    row = '{1'b0, glos_pkg::REG_GRID_WIDTH, '0, act, from_cell, to_cell, cost, known, want};
    plan = {plan, row};
  endfunction

  function automatic void add_reg(glos_pkg::cfg_idx_t sel, glos_pkg::reg_t val);
    plan_row_t row;
    row = '{1'b1, sel, val, glos_pkg::ACT_WRITE, '0, '0, '0, 1'b0, 1'b0};
    plan = {plan, row};
  endfunction

  // Hold start through back-to-back words; drop it only for an idle gap.
  task automatic send_word(logic act, glos_pkg::coord_t from_cell, glos_pkg::coord_t to_cell,
                           glos_pkg::cost_t cost);
    int gap;
    gap = 0;
    while (gap < 64 && $urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_action      <= act;
    in_start_index <= from_cell;
    in_end_index   <= to_cell;
    in_cell_cost   <= cost;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic write_cell(glos_pkg::coord_t at, glos_pkg::cost_t cost);
    send_word(glos_pkg::ACT_WRITE, at, glos_pkg::coord_t'($urandom), cost);
    grid_cost[at]    = cost;
    cell_written[at] = 1'b1;
  endtask

  // Write every unwritten in-range cell the line touches before the query goes out.
  task automatic run_query(glos_pkg::coord_t from_cell, glos_pkg::coord_t to_cell,
                           bit known, bit want);
    bit clear_bit;
    bit due_bit;
    do begin
      unwritten_at = -1;
      clear_bit = line_is_clear(from_cell, to_cell);
      if (unwritten_at >= 0) write_cell(glos_pkg::coord_t'(unwritten_at), pick_cost());
    end while (unwritten_at >= 0);
    send_word(glos_pkg::ACT_QUERY, from_cell, to_cell, glos_pkg::cost_t'($urandom));
    due_bit = known ? want : clear_bit;
    clear_bits_due = {clear_bits_due, due_bit};
  endtask

  task automatic random_query();
    longint w, x0, y0, x1, y1, span, idx;
    int shape;
    glos_pkg::coord_t s, e;
    s = pick_cell();
    e = s;
    if (grid_w_q != '0) begin
      w = longint'(grid_w_q);
      x0 = longint'(s) % w;
      y0 = longint'(s) / w;
      span = ($urandom_range(0, 31) == 0) ? 64 : 8;
      x1 = x0 + longint'($urandom_range(0, int'(2 * span))) - span;
      y1 = y0 + longint'($urandom_range(0, int'(2 * span))) - span;
      shape = $urandom_range(0, 15);
      if (shape == 0) y1 = y0;
      else if (shape == 1) x1 = x0;
      if (x1 < 0) x1 = 0;
      if (x1 >= w) x1 = w - 1;
      if (y1 < 0) y1 = 0;
      idx = y1 * w + x1;
      if (shape != 2 && idx < glos_pkg::GRID_CELLS) e = glos_pkg::coord_t'(idx);
    end else begin
      e = glos_pkg::coord_t'($urandom);
    end
    run_query(s, e, 1'b0, 1'b0);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (clear_bits_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(glos_pkg::cfg_idx_t sel, glos_pkg::reg_t val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      glos_pkg::REG_GRID_WIDTH:   grid_w_q = val;
      glos_pkg::REG_CELL_COUNT:   cell_cnt_q = val;
      glos_pkg::REG_CHEAP_THRESH: cheap_thr_q = val[glos_pkg::THR_W-1:0];
      default:                    ;
    endcase
  endtask

  always @(posedge clk) begin
    bit want;
    if (rst_n && out_valid) begin
      if (clear_bits_due.size() == 0) begin
        flag_error($sformatf("sight_clear word %0b with no query pending", out_sight_clear));
      end else begin
        want = clear_bits_due.pop_front();
        if (out_sight_clear !== want)
          flag_error($sformatf("sight_clear %0b, predicted %0b", out_sight_clear, want));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int ph, stop_at;
    glos_pkg::reg_t w, n, t;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    add_word(glos_pkg::ACT_QUERY, 16'd0, 16'd0, 8'd0, 1'b1, 1'b1);
    add_word(glos_pkg::ACT_QUERY, 16'd65535, 16'd65535, 8'd255, 1'b1, 1'b1);
    add_reg(glos_pkg::REG_GRID_WIDTH, 17'd4);
    add_reg(glos_pkg::REG_CELL_COUNT, 17'd16);
    add_reg(glos_pkg::REG_CHEAP_THRESH, 17'd200);
    add_word(glos_pkg::ACT_WRITE, 16'd5, 16'd65535, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_WRITE, 16'd6, 16'd0, 8'd255, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_WRITE, 16'd9, 16'd0, 8'd199, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_WRITE, 16'd10, 16'd0, 8'd200, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd5, 16'd6, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd6, 16'd5, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd5, 16'd9, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd9, 16'd5, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd5, 16'd10, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd10, 16'd5, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd1, 16'd14, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd12, 16'd3, 8'd0, 1'b0, 1'b0);
    add_reg(glos_pkg::REG_GRID_WIDTH, 17'd0);
    add_word(glos_pkg::ACT_QUERY, 16'd0, 16'd65535, 8'd0, 1'b1, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd65535, 16'd0, 8'd255, 1'b1, 1'b0);
    add_reg(glos_pkg::REG_GRID_WIDTH, 17'd65536);
    add_reg(glos_pkg::REG_CELL_COUNT, 17'd65536);
    add_word(glos_pkg::ACT_WRITE, 16'd65534, 16'd0, 8'd0, 1'b0, 1'b0);
    add_word(glos_pkg::ACT_QUERY, 16'd65535, 16'd65534, 8'd0, 1'b0, 1'b0);
    add_reg(glos_pkg::REG_CHEAP_THRESH, 17'd0);
    add_word(glos_pkg::ACT_QUERY, 16'd65535, 16'd65534, 8'd0, 1'b1, 1'b0);
    add_reg(glos_pkg::REG_CELL_COUNT, 17'd1);
    add_word(glos_pkg::ACT_QUERY, 16'd2, 16'd3, 8'd0, 1'b1, 1'b0);

    idle_pct = 15;
    foreach (plan[i]) begin
      if (plan[i].is_reg) write_reg(plan[i].reg_sel, plan[i].reg_val);
      else if (plan[i].act == glos_pkg::ACT_WRITE) write_cell(plan[i].from_cell, plan[i].cost);
      else run_query(plan[i].from_cell, plan[i].to_cell, plan[i].known, plan[i].want);
    end

    for (ph = 0; ph < 9; ph++) begin
      idle_pct = (ph < 3) ? 15 : (ph < 6) ? 75 : 0;
      case (ph)
        0: begin w = 17'd256;    n = 17'd65536;  t = 17'd150; end
        1: begin w = 17'd16;     n = 17'd200;    t = 17'd100; end
        2: begin w = 17'd1;      n = 17'd64;     t = 17'd256; end
        3: begin w = 17'd65536;  n = 17'd65536;  t = 17'd0;   end
        4: begin w = 17'd7;      n = 17'd1;      t = 17'd150; end
        5: begin w = 17'd100;    n = 17'd3000;   t = 17'd200; end
        6: begin w = 17'd131071; n = 17'd131071; t = 17'd511; end
        7: begin w = 17'd3;      n = 17'd40;     t = 17'd1;   end
        default: begin w = 17'd256; n = 17'd65536; t = 17'd150; end
      endcase
      write_reg(glos_pkg::REG_GRID_WIDTH, w);
      write_reg(glos_pkg::REG_CELL_COUNT, n);
      write_reg(glos_pkg::REG_CHEAP_THRESH, t);
      stop_at = items_sent + PHASE_WORDS;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 9) < 3) write_cell(pick_cell(), pick_cost());
        else random_query();
      end
    end

    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

/* sim.f */
rtl/glos_pkg.sv
rtl/glos_div.sv
rtl/grid_line_of_sight_check.sv
test/testbench.sv
